@@ hdl/mia_pkg.sv @@
// shared types, opcodes and cell arithmetic for the mips integer alu core
// no dependencies
package mia_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned CodeWidth   = 6;
   localparam int unsigned StallWidth  = 6;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned ShiftWidth  = 5;
   localparam int unsigned DivCells    = 32;
   localparam int unsigned MulCells    = 4;
   localparam int unsigned MulSlice    = DataWidth / MulCells;
   localparam int unsigned DepthWidth  = 6;
   localparam int unsigned Depth       = DivCells + 2;
   localparam logic [DataWidth-1:0] AllOnes = '1;

   // immediate class opcodes
   localparam logic [CodeWidth-1:0] OP_ADDI   = 6'h08;
   localparam logic [CodeWidth-1:0] OP_ADDI_U = 6'h09;
   localparam logic [CodeWidth-1:0] OP_SLTI   = 6'h0a;
   localparam logic [CodeWidth-1:0] OP_SLTI_U = 6'h0b;
   localparam logic [CodeWidth-1:0] OP_ANDI   = 6'h0c;
   localparam logic [CodeWidth-1:0] OP_ORI    = 6'h0d;
   localparam logic [CodeWidth-1:0] OP_XORI   = 6'h0e;
   localparam logic [CodeWidth-1:0] OP_LUI    = 6'h0f;
   // function class codes
   localparam logic [CodeWidth-1:0] FN_SLL     = 6'h00;
   localparam logic [CodeWidth-1:0] FN_SRL     = 6'h02;
   localparam logic [CodeWidth-1:0] FN_SRA     = 6'h03;
   localparam logic [CodeWidth-1:0] FN_SLLV    = 6'h04;
   localparam logic [CodeWidth-1:0] FN_SRLV    = 6'h06;
   localparam logic [CodeWidth-1:0] FN_SRAV    = 6'h07;
   localparam logic [CodeWidth-1:0] FN_JR      = 6'h08;
   localparam logic [CodeWidth-1:0] FN_JALR    = 6'h09;
   localparam logic [CodeWidth-1:0] FN_SYSCALL = 6'h0c;
   localparam logic [CodeWidth-1:0] FN_MULT    = 6'h18;
   localparam logic [CodeWidth-1:0] FN_MULTU   = 6'h19;
   localparam logic [CodeWidth-1:0] FN_DIV     = 6'h1a;
   localparam logic [CodeWidth-1:0] FN_DIVU    = 6'h1b;
   localparam logic [CodeWidth-1:0] FN_ADD     = 6'h20;
   localparam logic [CodeWidth-1:0] FN_ADDU    = 6'h21;
   localparam logic [CodeWidth-1:0] FN_SUB     = 6'h22;
   localparam logic [CodeWidth-1:0] FN_SUBU    = 6'h23;
   localparam logic [CodeWidth-1:0] FN_AND     = 6'h24;
   localparam logic [CodeWidth-1:0] FN_OR      = 6'h25;
   localparam logic [CodeWidth-1:0] FN_XOR     = 6'h26;
   localparam logic [CodeWidth-1:0] FN_NOR     = 6'h27;
   localparam logic [CodeWidth-1:0] FN_SLT     = 6'h2a;
   localparam logic [CodeWidth-1:0] FN_SLTU    = 6'h2b;

   localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
   localparam logic [StatusWidth-1:0] ST_UNDEF     = 3'd1;
   localparam logic [StatusWidth-1:0] ST_SYS_TRAP  = 3'd2;
   localparam logic [StatusWidth-1:0] ST_SYS_NOTED = 3'd3;
   localparam logic [StatusWidth-1:0] ST_DIV_ZERO  = 3'd4;

   localparam logic [0:0] REG_MUL_DELAY = 1'b0;
   localparam logic [0:0] REG_DIV_DELAY = 1'b1;

   // one request as it travels down the row of cells
   typedef struct packed {
      logic                   valid;
      logic                   is_mul;
      logic                   is_div;
      logic                   neg_q;
      logic                   neg_r;
      logic [DataWidth-1:0]   result;
      logic [StallWidth-1:0]  stall;
      logic [StatusWidth-1:0] status;
      logic [DataWidth-1:0]   divisor;
      logic [DataWidth-1:0]   rem;
      logic [DataWidth-1:0]   quo;
      logic [2*DataWidth-1:0] acc;
      logic [DataWidth-1:0]   mul_a;
      logic [DataWidth-1:0]   mul_b;
   } cell_type;

   function automatic logic [DataWidth-1:0] neg32(input logic [DataWidth-1:0] x);
      neg32 = ~x + 1'b1;
   endfunction

endpackage

@@ hdl/mia_cell.sv @@
// one cell of the row: a divide step and a multiply partial product
// depends on mia_pkg
module mia_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic [mia_pkg::DepthWidth-1:0] index,
   input  mia_pkg::cell_type              prev,
   output mia_pkg::cell_type              curr
);
   import mia_pkg::*;

   cell_type               curr_ff, curr_in;
   logic [DataWidth:0]     trial;
   logic [DataWidth-1:0]   shifted;
   logic [MulSlice+DataWidth-1:0] part;
   logic [1:0]             slice;

   // one restoring divide step plus one slice of the multiply
   always_comb begin
      curr_in = prev;
      shifted = {prev.rem[DataWidth-2:0], prev.quo[DataWidth-1]};
      trial   = {1'b0, shifted} - {1'b0, prev.divisor};
      if (prev.is_div && index < DepthWidth'(DivCells)) begin
         if (!trial[DataWidth] || prev.rem[DataWidth-1]) begin
            curr_in.rem = trial[DataWidth-1:0];
            curr_in.quo = {prev.quo[DataWidth-2:0], 1'b1};
         end else begin
            curr_in.rem = shifted;
            curr_in.quo = {prev.quo[DataWidth-2:0], 1'b0};
         end
      end
      slice = index[1:0];
      part  = prev.mul_a * prev.mul_b[slice*MulSlice +: MulSlice];
      if (prev.is_mul && index < DepthWidth'(MulCells))
         curr_in.acc = prev.acc + ({{DataWidth-MulSlice{1'b0}}, part} << (slice*MulSlice));
   end

   // hand over to the next cell
   always_ff @(posedge clock) begin
      if (reset)
         curr_ff.valid <= 1'b0;
      else if (enable)
         curr_ff.valid <= curr_in.valid;
      if (enable) begin
         curr_ff.is_mul  <= curr_in.is_mul;
         curr_ff.is_div  <= curr_in.is_div;
         curr_ff.neg_q   <= curr_in.neg_q;
         curr_ff.neg_r   <= curr_in.neg_r;
         curr_ff.result  <= curr_in.result;
         curr_ff.stall   <= curr_in.stall;
         curr_ff.status  <= curr_in.status;
         curr_ff.divisor <= curr_in.divisor;
         curr_ff.rem     <= curr_in.rem;
         curr_ff.quo     <= curr_in.quo;
         curr_ff.acc     <= curr_in.acc;
         curr_ff.mul_a   <= curr_in.mul_a;
         curr_ff.mul_b   <= curr_in.mul_b;
      end
   end

   assign curr = curr_ff;
endmodule

@@ hdl/mia_decode.sv @@
// decode stage: results of the simple ops and setup of multiply and divide
// depends on mia_pkg
module mia_decode (
   input  logic                           action,
   input  logic [mia_pkg::CodeWidth-1:0]  code,
   input  logic [mia_pkg::DataWidth-1:0]  operand_a,
   input  logic [mia_pkg::DataWidth-1:0]  operand_b,
   input  logic [mia_pkg::ShiftWidth-1:0] shamt,
   input  logic                           exceptions_disabled,
   input  logic [mia_pkg::StallWidth-1:0] mul_stall,
   input  logic [mia_pkg::StallWidth-1:0] div_stall,
   output mia_pkg::cell_type              item
);
   import mia_pkg::*;

   logic [DataWidth-1:0] a, b, sum, diff, mag_a, mag_b;
   logic                 lts, ltu;
   logic                 signed_op;

   always_comb begin
      a     = operand_a;
      b     = operand_b;
      sum   = a + b;
      diff  = a - b;
      ltu   = a < b;
      lts   = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
      signed_op = (code == FN_MULT) || (code == FN_DIV);
      mag_a = (signed_op && a[DataWidth-1]) ? neg32(a) : a;
      mag_b = (signed_op && b[DataWidth-1]) ? neg32(b) : b;
      item  = '0;
      item.valid  = 1'b1;
      item.result = AllOnes;
      item.status = ST_OK;
      if (!action) begin
         case (code)
            OP_ADDI, OP_ADDI_U: item.result = sum;
            OP_SLTI:   item.result = {31'd0, lts};
            OP_SLTI_U: item.result = {31'd0, ltu};
            OP_ANDI:   item.result = a & b;
            OP_ORI:    item.result = a | b;
            OP_XORI:   item.result = a ^ b;
            OP_LUI:    item.result = b << 16;
            default:   item.status = ST_UNDEF;
         endcase
      end else begin
         case (code)
            FN_SLL:  item.result = b << shamt;
            FN_SRL:  item.result = b >> shamt;
            FN_SRA:  item.result = DataWidth'($signed(b) >>> shamt);
            FN_SLLV: item.result = a << b[ShiftWidth-1:0];
            FN_SRLV: item.result = a >> b[ShiftWidth-1:0];
            FN_SRAV: item.result = DataWidth'($signed(a) >>> b[ShiftWidth-1:0]);
            FN_JR, FN_JALR: item.result = a;
            FN_SYSCALL: item.status = exceptions_disabled ? ST_SYS_NOTED : ST_SYS_TRAP;
            FN_MULT, FN_MULTU: begin
               item.is_mul = 1'b1;
               item.mul_a  = mag_a;
               item.mul_b  = mag_b;
               item.neg_q  = signed_op && (a[DataWidth-1] ^ b[DataWidth-1]);
               item.stall  = mul_stall;
            end
            FN_DIV, FN_DIVU: begin
               if (b == '0) item.status = ST_DIV_ZERO;
               else begin
                  item.is_div  = 1'b1;
                  item.quo     = mag_a;
                  item.divisor = mag_b;
                  item.neg_q   = signed_op && (a[DataWidth-1] ^ b[DataWidth-1]);
                  item.neg_r   = signed_op && a[DataWidth-1];
                  item.stall   = div_stall;
               end
            end
            FN_ADD, FN_ADDU: item.result = sum;
            FN_SUB, FN_SUBU: item.result = diff;
            FN_AND:  item.result = a & b;
            FN_OR:   item.result = a | b;
            FN_XOR:  item.result = a ^ b;
            FN_NOR:  item.result = ~(a | b);
            FN_SLT:  item.result = {31'd0, lts};
            FN_SLTU: item.result = {31'd0, ltu};
            default: item.status = ST_UNDEF;
         endcase
      end
   end
endmodule

@@ hdl/mips_integer_alu_core.sv @@
// Pipelined MIPS32 integer ALU. Every request flows through a fixed row of 34 cells and an
// output register, so a request is taken every cycle while the row is not stalled; every
// request passes the whole row (32 restoring divide cells, one quotient bit each, plus two
// pass cells), with the four 32x8 multiply slices sharing the first cells. The whole row
// stalls when the response register is full and not taken. Delay registers sit at csr
// addresses 0 and 4.
// depends on mia_pkg, mia_decode, mia_cell
module mips_integer_alu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // operand_a[31:0], operand_b[63:32], shift_amount[68:64]
   input  logic [7:0]  req_tuser,  // action[0], code[6:1], exceptions_disabled[7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [111:0] rsp_tdata, // result, hi_value, lo_value, hi_lo_written, stall, status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mia_pkg::*;

   logic [StallWidth-1:0] mul_stall_ff, div_stall_ff;
   cell_type              chain [0:Depth];
   cell_type              head;
   logic                  advance;
   logic [DataWidth-1:0]  hi, lo, quo_f, rem_f;
   logic [2*DataWidth-1:0] prod;
   logic [111:0]          out_ff;
   logic                  out_valid_ff;
   cell_type              tail;

   // configuration registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_stall_ff <= '0;
         div_stall_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_MUL_DELAY) mul_stall_ff <= csr_pwdata[StallWidth-1:0];
         else                               div_stall_ff <= csr_pwdata[StallWidth-1:0];
      end
   end
   assign csr_prdata = {26'd0, (csr_paddr[2] == REG_DIV_DELAY) ? div_stall_ff : mul_stall_ff};

   // decode into the first cell
   mia_decode u_decode (
      .action(req_tuser[0]), .code(req_tuser[6:1]),
      .operand_a(req_tdata[31:0]), .operand_b(req_tdata[63:32]),
      .shamt(req_tdata[68:64]), .exceptions_disabled(req_tuser[7]),
      .mul_stall(mul_stall_ff), .div_stall(div_stall_ff), .item(head)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      chain[0] = head;
      chain[0].valid = req_tvalid;
   end

   // row of cells
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      mia_cell u_cell (
         .clock(clock), .reset(reset), .enable(advance),
         .index(DepthWidth'(i)), .prev(chain[i]), .curr(chain[i+1])
      );
   end

   // sign fix-up and response register
   always_comb begin
      tail  = chain[Depth];
      prod  = tail.neg_q ? (~tail.acc + 1'b1) : tail.acc;
      quo_f = tail.neg_q ? neg32(tail.quo) : tail.quo;
      rem_f = tail.neg_r ? neg32(tail.rem) : tail.rem;
      hi = '0;
      lo = '0;
      if (tail.is_mul) begin
         hi = prod[2*DataWidth-1:DataWidth];
         lo = prod[DataWidth-1:0];
      end else if (tail.is_div) begin
         hi = rem_f;
         lo = quo_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (advance)
         out_valid_ff <= tail.valid;
      if (advance)
         out_ff <= {6'd0, tail.status, tail.stall, tail.is_mul | tail.is_div,
                    lo, hi, tail.result};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
endmodule
